>>> rtl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and helpers for the signed integer to ASCII core
// Holds character codes, BCD geometry and the double-dabble stage function.
// ----------------------------------------------------------------------------
`default_nettype none

package sitda_pkg;

  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned NUM_DIGITS     = 10;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned BCD_W          = NUM_DIGITS * DIGIT_W;
  localparam int unsigned BITS_PER_STAGE = 8;
  localparam int unsigned NUM_DABBLE     = VALUE_W / BITS_PER_STAGE;
  localparam int unsigned NUM_STAGES     = NUM_DABBLE + 1;
  localparam int unsigned POS_W          = $clog2(NUM_DIGITS);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

  typedef struct packed {
    logic               neg;
    bcd_t               bcd;
    logic [VALUE_W-1:0] mag;
  } stage_t;

  // Shift BITS_PER_STAGE magnitude bits into the BCD register, MSB first.
  function automatic stage_t dabble(input stage_t s);
    stage_t           r;
    logic [BCD_W-1:0] flat;
    r = s;
    for (int b = 0; b < BITS_PER_STAGE; b++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (r.bcd[d] >= 4'd5) begin
          r.bcd[d] = r.bcd[d] + 4'd3;
        end
      end
      flat  = r.bcd;
      r.bcd = {flat[BCD_W-2:0], r.mag[VALUE_W-1]};
      r.mag = {r.mag[VALUE_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/signed_int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core: 32-bit signed integer to decimal text
// Pipelined binary-to-BCD conversion followed by a one-character serializer.
// ----------------------------------------------------------------------------
// Each request on the input channel carries one 32-bit two's-complement value.
// The core returns its decimal text as a run of 1 to 11 character requests:
// '-' first for a negative value, then the digits most significant first with
// no leading zeros (zero gives a single '0'); last marks the final character.
// The conversion is a five-stage pipeline (a sign/magnitude stage, then four
// double-dabble stages of eight bits each) that takes a new value every cycle
// unless in_stall is high; each stage and then the serializer registers it.
// The serializer sends one character per cycle while out_stall is low, so the
// length of each run (1 to 11 characters) sets the sustained rate. Up to five
// further values queue in the pipeline while a run drains.
`default_nettype none

module signed_int_to_decimal_ascii_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [sitda_pkg::VALUE_W-1:0]  value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic        [sitda_pkg::CHAR_W-1:0]   char_code,
  output logic                                  last
);

  localparam int unsigned NS = sitda_pkg::NUM_STAGES;

  // Pipeline stages: stage 0 holds sign and magnitude, stages 1..4 dabble.
  sitda_pkg::stage_t st [NS];
  logic [NS-1:0]     st_valid;
  logic [NS-1:0]     en;

  // Serializer holding the run being sent.
  logic                                        ser_valid;
  logic                                        ser_minus;
  logic [sitda_pkg::POS_W-1:0]                 ser_pos;
  sitda_pkg::bcd_t                             ser_digits;
  logic                                        ser_ready;
  logic [sitda_pkg::POS_W-1:0]                 top_pos;
  logic [sitda_pkg::VALUE_W-1:0]               raw;

  assign raw = value;

  // Serializer takes a new run when empty or as its last character leaves.
  assign ser_ready = !ser_valid || (!out_stall && last);

  // A stage loads when it is empty or its content moves on this cycle.
  always_comb begin
    en[NS-1] = !st_valid[NS-1] || ser_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !st_valid[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];

  // Stage 0: form the magnitude; the most negative value wraps to 2^31 exactly.
  // Stages 1..4: advance eight magnitude bits each.
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
    end else begin
      if (en[0]) begin
        st_valid[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          st_valid[i] <= st_valid[i-1];
        end
      end
    end
    if (en[0]) begin
      st[0].neg <= raw[sitda_pkg::VALUE_W-1];
      st[0].mag <= raw[sitda_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;
      st[0].bcd <= '0;
    end
    for (int i = 1; i < NS; i++) begin
      if (en[i]) begin
        st[i] <= sitda_pkg::dabble(st[i-1]);
      end
    end
  end

  // Find the most significant nonzero digit; zero keeps position 0.
  always_comb begin
    top_pos = '0;
    for (int d = 0; d < sitda_pkg::NUM_DIGITS; d++) begin
      if (st[NS-1].bcd[d] != '0) begin
        top_pos = sitda_pkg::POS_W'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_minus <= 1'b0;
      ser_pos   <= '0;
    end else if (ser_ready) begin
      ser_valid <= st_valid[NS-1];
      if (st_valid[NS-1]) begin
        ser_minus  <= st[NS-1].neg;
        ser_pos    <= top_pos;
        ser_digits <= st[NS-1].bcd;
      end
    end else if (!out_stall) begin
      // Drop the sign first, then step down one digit per character.
      if (ser_minus) begin
        ser_minus <= 1'b0;
      end else begin
        ser_pos <= ser_pos - 1'b1;
      end
    end
  end

  assign out_valid = ser_valid;
  assign last      = !ser_minus && (ser_pos == '0);
  assign char_code = ser_minus ? sitda_pkg::CHAR_MINUS
                   : sitda_pkg::CHAR_ZERO + {3'b000, ser_digits[ser_pos]};

  // A sign is never the final character of a run.
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (char_code == sitda_pkg::CHAR_MINUS) |-> !last)
    else $error("minus sign flagged as last");

  // Characters are a sign or a decimal digit.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == sitda_pkg::CHAR_MINUS) ||
                  ((char_code >= sitda_pkg::CHAR_ZERO) &&
                   (char_code <= sitda_pkg::CHAR_NINE)))
    else $error("character outside sign and digit set");

  // A run continues after a non-final character is taken.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("run ended without last flag");

  // The last stage holds its value while the serializer is busy.
  a_tail_holds: assert property (@(posedge clk) disable iff (rst)
    st_valid[NS-1] && !ser_ready |=> st_valid[NS-1])
    else $error("pipeline tail dropped a value");

  // The digit index never leaves the BCD register.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    ser_valid |-> ser_pos < sitda_pkg::POS_W'(sitda_pkg::NUM_DIGITS))
    else $error("digit index out of range");

endmodule

`default_nettype wire
